// ===== hdl/slr_pkg.sv =====
// Shared constants and types for the shuffled Lehmer random generator.
package slr_pkg;

   localparam int VALUE_W = 31;
   localparam int MULT_W = 15;
   localparam int PROD_W = VALUE_W + MULT_W;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int WARM_EXTRA = 8;

   localparam logic [31:0] LEHMER_M = 32'd2147483647;
   localparam logic [MULT_W-1:0] LEHMER_A = 15'd16807;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] DEFAULT_SEED_ADDR = 2'd0;
   localparam logic [VALUE_W-1:0] DEFAULT_SEED_RESET = 31'd1931;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_RESEED = 1'b1;

   typedef logic [VALUE_W-1:0] value_type;

endpackage

// ===== hdl/slr_if.sv =====
// Request and response channel interfaces of the shuffled Lehmer random generator.
interface slr_req_if import slr_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      action;
   value_type seed_value;

   modport source (output valid, output action, output seed_value, input ready);
   modport sink (input valid, input action, input seed_value, output ready);
endinterface

interface slr_rsp_if import slr_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

// ===== hdl/slr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/slr_lehmer.sv =====
// Shared Lehmer step unit: multiply by 16807, then fold modulo 2^31-1.
module slr_lehmer import slr_pkg::*; (
   input  logic      clock,
   input  logic      start,
   input  value_type operand,
   output value_type result
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [31:0]       fold_sum;
   logic [31:0]       fold_red;

   assign prod_in = {{MULT_W{1'b0}}, operand} * {{VALUE_W{1'b0}}, LEHMER_A};

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      fold_sum = {1'b0, prod_ff[VALUE_W-1:0]}
               + {{(32-MULT_W){1'b0}}, prod_ff[PROD_W-1:VALUE_W]};
      fold_red = (fold_sum >= LEHMER_M) ? fold_sum - LEHMER_M : fold_sum;
   end

   assign result = fold_red[VALUE_W-1:0];

endmodule

// ===== hdl/slr_index.sv =====
// Bucket compare that maps the previous output to a shuffle table index.
module slr_index import slr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           start,
   input  value_type                      dividend,
   output logic [$clog2(TABLE_DEPTH)-1:0] index
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [31:0] BUCKET = 32'(1 + (LEHMER_M - 1) / TABLE_DEPTH);

   logic [IDX_W-1:0] index_ff, index_in;
   logic [31:0]      value_ext;

   assign value_ext = {1'b0, dividend};

   // take the highest bucket whose lower bound the value reaches
   always_comb begin
      index_in = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if (value_ext >= 32'(k) * BUCKET) begin
            index_in = IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         index_ff <= index_in;
      end
   end

   assign index = index_ff;

endmodule

// ===== hdl/shuffled_lehmer_random.sv =====
// Top level of the shuffled Lehmer random generator and its sequencer.
// Draw: the result goes valid after the Lehmer multiply, bucket compare for the index,
// registered RAM read and table write; a response not yet taken stalls the table write.
// Reseed, or first draw after reset: TABLE_DEPTH+8 warm-up values come first, one Lehmer
// step per warm-up value. One item in work at a time; a request is taken only in ST_IDLE.
// Synchronous reset clears control and the generator state and loads default_seed (1931).
module shuffled_lehmer_random import slr_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   slr_req_if.sink               req_chan,
   slr_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int WCNT_W = $clog2(TABLE_DEPTH + WARM_EXTRA);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_WARM_MUL   = 7'b0000010,
      ST_WARM_RED   = 7'b0000100,
      ST_DRAW_MUL   = 7'b0001000,
      ST_DRAW_DIV   = 7'b0010000,
      ST_DRAW_READ  = 7'b0100000,
      ST_DRAW_WRITE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   value_type         seed_reg_ff, seed_reg_in;
   value_type         gen_ff, gen_in;
   value_type         last_ff, last_in;
   value_type         walk_ff, walk_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   value_type         rsp_data_ff, rsp_data_in;

   value_type         seed_raw;
   value_type         seed_norm;
   logic              req_fire;
   logic              csr_write;

   logic              lm_start;
   value_type         lm_operand;
   value_type         lm_result;
   logic              ix_start;
   logic [IDX_W-1:0]  ix_index;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   value_type         ram_wr_data;
   logic              ram_rd_en;
   value_type         ram_rd_data;

   slr_lehmer u_lehmer (
      .clock   (clock),
      .start   (lm_start),
      .operand (lm_operand),
      .result  (lm_result)
   );

   slr_index #(.TABLE_DEPTH(TABLE_DEPTH)) u_index (
      .clock    (clock),
      .start    (ix_start),
      .dividend (last_ff),
      .index    (ix_index)
   );

   slr_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ix_index),
      .rd_data (ram_rd_data)
   );

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == DEFAULT_SEED_ADDR) ?
                       {{(CSR_DATA_W-VALUE_W){1'b0}}, seed_reg_ff} : '0;

   assign req_chan.ready = state_ff == ST_IDLE;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_data_ff;

   always_comb begin
      seed_raw = (req_chan.action == ACTION_RESEED) ? req_chan.seed_value : seed_reg_ff;
      seed_norm = seed_raw;
      if (seed_raw == '0 || {1'b0, seed_raw} == LEHMER_M) begin
         seed_norm = value_type'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      seed_reg_in = csr_write ? csr_pwdata[VALUE_W-1:0] : seed_reg_ff;
      gen_in = gen_ff;
      last_in = last_ff;
      walk_in = walk_ff;
      wcnt_in = wcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      lm_start = 1'b0;
      lm_operand = gen_ff;
      ix_start = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_addr = wcnt_ff[IDX_W-1:0];
      ram_wr_data = lm_result;
      ram_rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               walk_in = seed_norm;
               wcnt_in = WCNT_W'(TABLE_DEPTH + WARM_EXTRA - 1);
               if (req_chan.action == ACTION_RESEED || last_ff == '0) begin
                  state_in = ST_WARM_MUL;
               end else begin
                  state_in = ST_DRAW_MUL;
               end
            end
         end
         ST_WARM_MUL: begin
            lm_start = 1'b1;
            lm_operand = walk_ff;
            state_in = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            walk_in = lm_result;
            ram_wr_en = wcnt_ff < WCNT_W'(TABLE_DEPTH);
            if (wcnt_ff == '0) begin
               gen_in = lm_result;
               last_in = lm_result;
               state_in = ST_DRAW_MUL;
            end else begin
               wcnt_in = wcnt_ff - 1'b1;
               state_in = ST_WARM_MUL;
            end
         end
         ST_DRAW_MUL: begin
            lm_start = 1'b1;
            ix_start = 1'b1;
            state_in = ST_DRAW_DIV;
         end
         ST_DRAW_DIV: begin
            gen_in = lm_result;
            state_in = ST_DRAW_READ;
         end
         ST_DRAW_READ: begin
            ram_rd_en = 1'b1;
            state_in = ST_DRAW_WRITE;
         end
         ST_DRAW_WRITE: begin
            ram_wr_addr = ix_index;
            ram_wr_data = gen_ff;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               ram_wr_en = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in = ram_rd_data;
               last_in = ram_rd_data;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seed_reg_ff <= DEFAULT_SEED_RESET;
         gen_ff <= '0;
         last_ff <= '0;
         wcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         seed_reg_ff <= seed_reg_in;
         gen_ff <= gen_in;
         last_ff <= last_in;
         wcnt_ff <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff <= walk_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== hdl/slr_checker.sv =====
// Port-level assertions for the shuffled Lehmer random generator, with its bind.
module slr_checker import slr_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input value_type random_value
);

   logic [1:0] pending_ff, pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(random_value))
      else $error("stalled item dropped or changed");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> random_value != '0 && {1'b0, random_value} != LEHMER_M)
      else $error("item value outside generator range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while previous item in work");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> pending_ff != 2'd0) and (pending_ff != 2'd3))
      else $error("item count out of step");

endmodule

bind shuffled_lehmer_random slr_checker u_slr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .random_value (rsp_chan.random_value)
);
